[rtl/mse_pkg.sv]
// Package for the multi-stack engine: sizes, codes, state and control types.
package mse_pkg;

    localparam int NUM_STACKS  = 8;
    localparam int STACK_DEPTH = 16;
    localparam int WORD_WIDTH  = 32;

    localparam int OP_W    = 2;
    localparam int SN_W    = 3;
    localparam int VAL_W   = 32;
    localparam int ST_W    = 2;
    localparam int CFG_W   = 4;
    localparam int LIM_W   = 8;
    localparam int SIDX_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W  = $clog2(NUM_STACKS * STACK_DEPTH);
    localparam int EXT_W   = 64;
    localparam int S_DATA_W = ((SN_W + VAL_W + 7) / 8) * 8;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_BAD_ID    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_DONE = 2'd2
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

[rtl/mse_ctrl.sv]
// Controller state machine of the multi-stack engine.
module mse_ctrl
    import mse_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: n_state = S_DONE;
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready     = 1'b0;
        o_cmd          = '0;
        case (r_state)
            S_IDLE: begin
                o_s_tready    = 1'b1;
                o_cmd.capture = i_s_tvalid;
            end
            S_EXEC: o_cmd.exec = 1'b1;
            S_DONE: o_cmd.load_out = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

[rtl/mse_dpath.sv]
// Datapath of the multi-stack engine: fill counts, shared stack store, result register.
module mse_dpath
    import mse_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wen,
    input  logic [CFG_W-1:0]    i_cfg_wdata,
    input  logic [OP_W-1:0]     i_op,
    input  logic [SN_W-1:0]     i_sn,
    input  logic [VAL_W-1:0]    i_pv,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic                i_m_tready,
    output logic                o_m_tvalid,
    output logic [VAL_W-1:0]    o_read_value,
    output logic [ST_W-1:0]     o_status
);

    logic [CFG_W-1:0]                  r_siu;
    t_op                               r_op;
    logic [SN_W-1:0]                   r_sn;
    logic [VAL_W-1:0]                  r_pv;
    logic [NUM_STACKS-1:0][CNT_W-1:0]  r_fill;
    t_status                           r_st;
    logic                              r_rd_ok;
    logic [WORD_WIDTH-1:0]             r_rdata;
    logic                              r_out_valid;
    logic [VAL_W-1:0]                  r_out_data;
    t_status                           r_out_st;
    logic [WORD_WIDTH-1:0]             mem [NUM_STACKS*STACK_DEPTH];

    logic [LIM_W-1:0]  lim;
    logic              bad;
    logic [SIDX_W-1:0] sidx;
    logic [CNT_W-1:0]  cnt;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] addr;
    t_status           n_st;
    logic              n_rd_ok;
    logic              wr_en;
    logic [CNT_W-1:0]  n_cnt;
    logic [EXT_W-1:0]  ext;

    always_comb begin
        lim     = (LIM_W'(r_siu) < LIM_W'(NUM_STACKS)) ? LIM_W'(r_siu) : LIM_W'(NUM_STACKS);
        bad     = (LIM_W'(r_sn) >= lim);
        sidx    = SIDX_W'(r_sn);
        cnt     = r_fill[sidx];
        base    = ADDR_W'(r_sn) * ADDR_W'(STACK_DEPTH);
        n_st    = ST_OK;
        n_rd_ok = 1'b0;
        wr_en   = 1'b0;
        n_cnt   = cnt;
        addr    = base + ADDR_W'(cnt - CNT_W'(1));
        case (r_op)
            OP_PUSH: begin
                addr = base + ADDR_W'(cnt);
                if (bad) begin
                    n_st = ST_BAD_ID;
                end else if (cnt >= CNT_W'(STACK_DEPTH)) begin
                    n_st = ST_OVERFLOW;
                end else begin
                    wr_en = 1'b1;
                    n_cnt = cnt + CNT_W'(1);
                end
            end
            OP_POP, OP_PEEK: begin
                if (bad) begin
                    n_st = ST_BAD_ID;
                end else if (cnt == '0) begin
                    n_st = ST_UNDERFLOW;
                end else begin
                    n_rd_ok = 1'b1;
                    if (r_op == OP_POP) begin
                        n_cnt = cnt - CNT_W'(1);
                    end
                end
            end
            default: n_st = ST_OK;
        endcase
    end

    assign ext   = EXT_W'(signed'(r_rdata));
    assign o_sts.out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_siu       <= CFG_RESET;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_siu <= i_cfg_wdata;
            end
            if (i_cmd.exec) begin
                r_fill[sidx] <= n_cnt;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op <= t_op'(i_op);
            r_sn <= i_sn;
            r_pv <= i_pv;
        end
        if (i_cmd.exec) begin
            r_st    <= n_st;
            r_rd_ok <= n_rd_ok;
        end
        if (i_cmd.load_out) begin
            r_out_st   <= r_st;
            r_out_data <= r_rd_ok ? ext[VAL_W-1:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            mem[addr] <= WORD_WIDTH'(r_pv);
        end
        if (i_cmd.exec) begin
            r_rdata <= mem[addr];
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_read_value = r_out_data;
    assign o_status     = r_out_st;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || i_m_tready))
        else $error("result loaded over an untaken word");

    a_err_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && (n_st != ST_OK)) |=> $stable(r_fill))
        else $error("fill count changed on a failed request");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_st != ST_OK)) |-> (r_out_data == '0))
        else $error("nonzero read value with error status");

endmodule

[rtl/multi_stack_engine.sv]
// Top level of the multi-stack engine: several LIFO stacks in one shared store.
//
// Input channel (s): one word per request. tuser carries the operation
// (push, pop, peek; the unused code answers ok with no effect), tdata the
// stack number and the value to push. Output channel (m): one word per
// request, tdata the read value, tuser the status (ok, overflow, underflow,
// bad stack number). Failed requests change no state.
// Configuration: i_cfg_wen with i_cfg_wdata writes the number of enabled
// stacks; write it only while no request is in flight.
// Requests are taken one at a time, only in the idle state; each goes through
// capture, store access with its registered read port, and result load, which
// waits for a free output register and raises o_m_tvalid.
// A new request is accepted while a finished result waits in the output
// register; if the receiver stalls, the next result waits in the datapath and
// input is held off until the output register frees.
// Reset (synchronous, active low) empties every stack, sets the enabled stack
// count to 8 and drops o_m_tvalid. The store itself is not cleared.
module multi_stack_engine
    import mse_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wen,
    input  logic [CFG_W-1:0]    i_cfg_wdata,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,  // stack_number, push_value, zero pad
    input  logic [OP_W-1:0]     i_s_tuser,  // op
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [VAL_W-1:0]    o_m_tdata,  // read_value
    output logic [ST_W-1:0]     o_m_tuser   // status
);

    t_cmd cmd;
    t_sts sts;

    mse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mse_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_op         (i_s_tuser),
        .i_sn         (i_s_tdata[SN_W-1:0]),
        .i_pv         (i_s_tdata[SN_W+VAL_W-1:SN_W]),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_m_tready   (i_m_tready),
        .o_m_tvalid   (o_m_tvalid),
        .o_read_value (o_m_tdata),
        .o_status     (o_m_tuser)
    );

endmodule
